// ===== hw/rtl/mcra_pkg.sv =====
// Shared types and constants of the MMU context recency allocator.
`default_nettype none

package mcra_pkg;

  localparam int NUM_CONTEXTS_DEF = 64;
  localparam int OWNER_BITS_DEF   = 16;
  localparam int CTX_PORT_W       = 6;
  localparam int OWNER_PORT_W     = 16;
  localparam int CTX_W_DEF        = $clog2(NUM_CONTEXTS_DEF);

  typedef enum logic [1:0] {
    ACT_ALLOCATE,
    ACT_RELEASE,
    ACT_CLEAR,
    ACT_POPULATE
  } action_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_INDEX,
    ST_NOT_OWNED
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_MATCH,
    CELL_FRONT,
    CELL_BACK
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcra_cell.sv =====
// One slot of the recency order: holds a context number and shifts with its neighbors.
`default_nettype none

module mcra_cell import mcra_pkg::*; #(
  parameter int CTX_W    = CTX_W_DEF,
  parameter int INIT_VAL = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_op_t         op,
  input  wire logic [CTX_W-1:0] key,
  input  wire logic [CTX_W-1:0] above_val,
  input  wire logic [CTX_W-1:0] below_val,
  input  wire logic             above_seen,
  input  wire logic             below_seen,
  output logic      [CTX_W-1:0] val,
  output logic                  seen_up,
  output logic                  seen_down
);

  logic match;
  logic active_front;
  logic active_back;

  // The key sits at this slot or beyond it (toward the victim end)
  assign active_front = match | below_seen;
  // The key sits at this slot or before it (toward the most-recent end)
  assign active_back  = match | above_seen;
  assign seen_up      = active_front;
  assign seen_down    = active_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      val   <= CTX_W'(INIT_VAL);
      match <= 1'b0;
    end else begin
      unique case (op)
        CELL_HOLD: begin
        end
        CELL_MATCH: begin
          match <= (val == key);
        end
        CELL_FRONT: begin
          if (active_front) val <= above_val;
        end
        CELL_BACK: begin
          if (active_back) val <= below_val;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mcra_chain.sv =====
// Row of recency cells, slot 0 most recent, last slot the victim.
`default_nettype none

module mcra_chain import mcra_pkg::*; #(
  parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
  parameter int CTX_W        = CTX_W_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_op_t         op,
  input  wire logic [CTX_W-1:0] key,
  output logic      [CTX_W-1:0] victim
);

  localparam int SLOTS = NUM_CONTEXTS - 1;

  logic [CTX_W-1:0] vals [SLOTS];
  logic [SLOTS-1:0] seen_up;
  logic [SLOTS-1:0] seen_down;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    logic [CTX_W-1:0] above_val;
    logic [CTX_W-1:0] below_val;
    logic             above_seen;
    logic             below_seen;

    // The key enters at the most-recent end on a move to front
    if (k == 0) begin : g_head
      assign above_val  = key;
      assign above_seen = 1'b0;
    end else begin : g_mid_head
      assign above_val  = vals[k-1];
      assign above_seen = seen_down[k-1];
    end

    // The key enters at the victim end on a move to back
    if (k == SLOTS - 1) begin : g_tail
      assign below_val  = key;
      assign below_seen = 1'b0;
    end else begin : g_mid_tail
      assign below_val  = vals[k+1];
      assign below_seen = seen_up[k+1];
    end

    mcra_cell #(
      .CTX_W    (CTX_W),
      .INIT_VAL (k + 1)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .key        (key),
      .above_val  (above_val),
      .below_val  (below_val),
      .above_seen (above_seen),
      .below_seen (below_seen),
      .val        (vals[k]),
      .seen_up    (seen_up[k]),
      .seen_down  (seen_down[k])
    );
  end

  assign victim = vals[SLOTS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/mmu_context_recency_allocator.sv =====
// MMU context recency allocator: hands out address space ids in least-recent-first order.
// Flow: start is taken while idle (busy low); the command is captured, then a match pass over the
//   recency cells with the owner memory read, then the shift and bookkeeping update; the result
//   and done are registered after that update. A new command is taken only once idle again.
// Reset: the recency cells reload 1..NUM_CONTEXTS-1 and all owned and populated bits
//   clear at once; no clearing pass. The receiver cannot stall the result.
`default_nettype none

module mmu_context_recency_allocator import mcra_pkg::*; #(
  parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
  parameter int OWNER_BITS   = OWNER_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              action,
  input  wire logic [OWNER_PORT_W-1:0] owner,
  input  wire logic [CTX_PORT_W-1:0]   ctx_index,
  output logic                         done,
  output logic      [CTX_PORT_W-1:0]   ctx_out,
  output logic                         evicted,
  output logic      [OWNER_PORT_W-1:0] evicted_owner,
  output logic                         purge,
  output logic      [1:0]              status
);

  localparam int CW = $clog2(NUM_CONTEXTS);
  localparam int IW = (CW > CTX_PORT_W) ? CW : CTX_PORT_W;
  localparam int OW = (OWNER_BITS < OWNER_PORT_W) ? OWNER_BITS : OWNER_PORT_W;

  state_t state;
  state_t state_next;

  action_t              act;
  logic [OW-1:0]        own_in;
  logic [CTX_PORT_W-1:0] idx_raw;
  logic                 idx_ok;
  logic [CW-1:0]        tgt;
  logic [OW-1:0]        owner_rd;
  logic [OW-1:0]        owner_mem [NUM_CONTEXTS];
  logic [NUM_CONTEXTS-1:0] owned;
  logic [NUM_CONTEXTS-1:0] populated;

  logic [CW-1:0] victim;
  logic [IW-1:0] idx_w;
  logic [IW-1:0] tgt_w;
  logic          accept;

  cell_op_t cell_op;
  logic     res_load;
  logic     own_set;
  logic     detach;
  logic     pop_set;

  logic [CTX_PORT_W-1:0]   res_ctx;
  logic                    res_evicted;
  logic [OWNER_PORT_W-1:0] res_owner;
  logic                    res_purge;
  status_t                 res_status;

  assign idx_w  = IW'(ctx_index);
  assign tgt_w  = IW'(tgt);
  assign accept = start && !busy;

  mcra_chain #(
    .NUM_CONTEXTS (NUM_CONTEXTS),
    .CTX_W        (CW)
  ) u_chain (
    .clk    (clk),
    .rst    (rst),
    .op     (cell_op),
    .key    (tgt),
    .victim (victim)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and update decisions
  always_comb begin
    busy        = 1'b1;
    cell_op     = CELL_HOLD;
    res_load    = 1'b0;
    own_set     = 1'b0;
    detach      = 1'b0;
    pop_set     = 1'b0;
    res_ctx     = idx_raw;
    res_evicted = 1'b0;
    res_owner   = '0;
    res_purge   = 1'b0;
    res_status  = ST_OK;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_READ: begin
        cell_op = CELL_MATCH;
      end
      S_EXEC: begin
        res_load = 1'b1;
        if (act == ACT_ALLOCATE) begin
          res_ctx     = tgt_w[CTX_PORT_W-1:0];
          res_evicted = owned[tgt];
          res_owner   = owned[tgt] ? OWNER_PORT_W'(owner_rd) : '0;
          res_purge   = owned[tgt] && populated[tgt];
          own_set     = 1'b1;
          cell_op     = CELL_FRONT;
        end else if (!idx_ok) begin
          res_status = ST_BAD_INDEX;
        end else if (!owned[tgt]) begin
          res_status = ST_NOT_OWNED;
        end else if (act == ACT_POPULATE) begin
          pop_set = 1'b1;
        end else begin
          // Release and clear both detach; release also drops to the victim end
          res_evicted = 1'b1;
          res_owner   = OWNER_PORT_W'(owner_rd);
          res_purge   = populated[tgt];
          detach      = 1'b1;
          if (act == ACT_RELEASE) cell_op = CELL_BACK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Capture the command; allocate targets the current victim
  always_ff @(posedge clk) begin
    if (accept) begin
      act     <= action_t'(action);
      own_in  <= owner[OW-1:0];
      idx_raw <= ctx_index;
      idx_ok  <= (ctx_index != '0) && (32'(ctx_index) < NUM_CONTEXTS);
      tgt     <= (action_t'(action) == ACT_ALLOCATE) ? victim : idx_w[CW-1:0];
    end
  end

  // Owner memory: read in the match cycle, written on allocate
  always_ff @(posedge clk) begin
    if (state == S_READ) owner_rd <= owner_mem[tgt];
    if (own_set) owner_mem[tgt] <= own_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owned     <= '0;
      populated <= '0;
    end else begin
      if (own_set || detach) begin
        owned[tgt]     <= own_set;
        populated[tgt] <= 1'b0;
      end
      if (pop_set) populated[tgt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= res_load;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      ctx_out       <= res_ctx;
      evicted       <= res_evicted;
      evicted_owner <= res_owner;
      purge         <= res_purge;
      status        <= res_status;
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the MMU context recency allocator.
`timescale 1ns / 1ps

module testbench;
  import mcra_pkg::*;

  localparam int NCTX      = 64;
  localparam int ORDER_N   = NCTX - 1;
  localparam int N_RANDOM  = 750;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    action_t     act;
    logic [15:0] who;
    logic [5:0]  idx;
    int          gap;
    bit          drain;
  } ctx_cmd_t;

  typedef struct {
    logic [5:0]  ctx;
    logic        evict;
    logic [15:0] evict_owner;
    logic        flush;
    status_t     st;
  } ctx_reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  action = '0;
  logic [15:0] owner = '0;
  logic [5:0]  ctx_index = '0;
  wire         busy;
  wire         done;
  wire  [5:0]  ctx_out;
  wire         evicted;
  wire  [15:0] evicted_owner;
  wire         purge;
  wire  [1:0]  status;

  mmu_context_recency_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .owner(owner), .ctx_index(ctx_index),
    .done(done), .ctx_out(ctx_out), .evicted(evicted),
    .evicted_owner(evicted_owner), .purge(purge), .status(status)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Shadow copy of the allocator state
  logic [5:0]  lru_slots [ORDER_N];
  logic [15:0] owner_of  [NCTX];
  bit          is_owned  [NCTX];
  bit          has_root  [NCTX];

  ctx_cmd_t   pending_cmds [$];
  ctx_reply_t expected_replies [$];
  ctx_cmd_t   cur_cmd;
  bit         have_cur = 0;
  int         hold_off = 0;
  int         in_flight = 0;

  int n_cmds = 0, n_alloc = 0, n_evict = 0, n_purge = 0, n_err = 0;
  int n_replies = 0, n_mismatch = 0;

  function automatic int find_slot(logic [5:0] c);
    for (int i = 0; i < ORDER_N; i++)
      if (lru_slots[i] == c) return i;
    return ORDER_N - 1;
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < ORDER_N; i++) lru_slots[i] = 6'(i + 1);
    for (int i = 0; i < NCTX; i++) begin
      owner_of[i] = '0;
      is_owned[i] = 0;
      has_root[i] = 0;
    end
  endfunction

  function automatic void detach_owner(logic [5:0] c, ref ctx_reply_t r);
    r.evict       = 1'b1;
    r.evict_owner = owner_of[c];
    r.flush       = has_root[c];
    n_evict++;
    if (has_root[c]) n_purge++;
    is_owned[c] = 0;
    has_root[c] = 0;
    owner_of[c] = '0;
  endfunction

  // Apply one command to the shadow state and queue the reply it must produce
  function automatic void track_context_cmd(ctx_cmd_t c);
    ctx_reply_t r;
    logic [5:0] victim;
    int         slot;
    r = '{ctx: c.idx, evict: 1'b0, evict_owner: '0, flush: 1'b0, st: ST_OK};
    n_cmds++;
    if (c.act == ACT_ALLOCATE) begin
      n_alloc++;
      victim = lru_slots[ORDER_N - 1];
      r.ctx  = victim;
      if (is_owned[victim]) detach_owner(victim, r);
      owner_of[victim] = c.who;
      is_owned[victim] = 1;
      has_root[victim] = 0;
      for (int i = ORDER_N - 1; i > 0; i--) lru_slots[i] = lru_slots[i - 1];
      lru_slots[0] = victim;
    end else if (c.idx == 0) begin
      r.st = ST_BAD_INDEX;
      n_err++;
    end else if (!is_owned[c.idx]) begin
      r.st = ST_NOT_OWNED;
      n_err++;
    end else if (c.act == ACT_RELEASE) begin
      detach_owner(c.idx, r);
      slot = find_slot(c.idx);
      for (int i = slot; i < ORDER_N - 1; i++) lru_slots[i] = lru_slots[i + 1];
      lru_slots[ORDER_N - 1] = c.idx;
    end else if (c.act == ACT_CLEAR) begin
      detach_owner(c.idx, r);
    end else begin
      has_root[c.idx] = 1;
    end
    expected_replies.push_back(r);
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic void add_cmd(action_t a, logic [15:0] w, logic [5:0] i, bit burst,
                                  bit drain);
    ctx_cmd_t c;
    c.act   = a;
    c.who   = w;
    c.idx   = i;
    c.gap   = pick_gap(burst);
    c.drain = drain;
    pending_cmds.push_back(c);
  endfunction

  // Driver: hold start until the transfer, then fetch the next command
  always @(posedge clk) begin : drive_cmds
    bit take;
    bit raise;
    if (rst) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      in_flight = in_flight + (take ? 1 : 0) - (done ? 1 : 0);
      if (take) begin
        track_context_cmd(cur_cmd);
        have_cur = 0;
      end
      if (!start || take) begin
        if (!have_cur && pending_cmds.size() > 0) begin
          cur_cmd  = pending_cmds.pop_front();
          hold_off = cur_cmd.gap;
          have_cur = 1;
        end
        raise = 0;
        if (have_cur) begin
          if (hold_off > 0) hold_off--;
          else if (!(cur_cmd.drain && in_flight != 0)) raise = 1;
        end
        start <= raise;
        if (raise) begin
          action    <= cur_cmd.act;
          owner     <= cur_cmd.who;
          ctx_index <= cur_cmd.idx;
        end else begin
          action    <= 2'($urandom);
          owner     <= 16'($urandom);
          ctx_index <= 6'($urandom);
        end
      end
    end
  end

  // Monitor: every done strobe must match the oldest expected reply
  always @(posedge clk) begin : check_replies
    ctx_reply_t e;
    bit bad;
    if (!rst && done) begin
      n_replies++;
      if (expected_replies.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_SHOWN)
          $display("[%0t] unexpected reply: ctx=%0d status=%0d", $realtime, ctx_out, status);
      end else begin
        e = expected_replies.pop_front();
        bad = (ctx_out !== e.ctx) || (evicted !== e.evict) ||
              (evicted_owner !== e.evict_owner) || (purge !== e.flush) ||
              (status !== e.st);
        if (bad) begin
          n_mismatch++;
          if (n_mismatch <= MAX_SHOWN) begin
            $display("[%0t] reply mismatch: exp ctx=%0d ev=%0b evo=%h pg=%0b st=%0d",
                     $realtime, e.ctx, e.evict, e.evict_owner, e.flush, e.st);
            $display("          got ctx=%0d ev=%0b evo=%h pg=%0b st=%0d",
                     ctx_out, evicted, evicted_owner, purge, status);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    bit burst;
    action_t a;
    logic [5:0] i;
    reset_shadow();

    // Directed: error cases from reset, then allocate, populate, release and clear paths
    add_cmd(ACT_RELEASE,  16'h0000, 6'd5,  0, 0);
    add_cmd(ACT_CLEAR,    16'h0000, 6'd0,  0, 0);
    add_cmd(ACT_POPULATE, 16'h0000, 6'd0,  0, 0);
    add_cmd(ACT_RELEASE,  16'hFFFF, 6'd0,  0, 0);
    add_cmd(ACT_POPULATE, 16'h0000, 6'd63, 0, 0);
    add_cmd(ACT_ALLOCATE, 16'hFFFF, 6'd0,  0, 0);
    add_cmd(ACT_ALLOCATE, 16'h0000, 6'd63, 0, 0);
    add_cmd(ACT_POPULATE, 16'h0000, 6'd63, 0, 0);
    add_cmd(ACT_POPULATE, 16'hFFFF, 6'd63, 0, 0);
    add_cmd(ACT_RELEASE,  16'h0000, 6'd63, 0, 0);
    add_cmd(ACT_ALLOCATE, 16'h1234, 6'd17, 0, 0);
    add_cmd(ACT_CLEAR,    16'h0000, 6'd62, 0, 0);
    add_cmd(ACT_CLEAR,    16'h0000, 6'd62, 0, 0);
    add_cmd(ACT_POPULATE, 16'h0000, 6'd62, 0, 0);
    add_cmd(ACT_RELEASE,  16'h0000, 6'd62, 0, 0);
    add_cmd(ACT_POPULATE, 16'h0000, 6'd63, 0, 1);
    add_cmd(ACT_ALLOCATE, 16'hA5A5, 6'd63, 0, 1);
    add_cmd(ACT_CLEAR,    16'h0000, 6'd63, 0, 0);
    add_cmd(ACT_ALLOCATE, 16'h5A5A, 6'd0,  0, 0);

    // Random: allocation-heavy so the order wraps and evictions occur
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45)      a = ACT_ALLOCATE;
      else if (r < 70) a = ACT_POPULATE;
      else if (r < 85) a = ACT_RELEASE;
      else             a = ACT_CLEAR;
      i = ($urandom_range(0, 19) == 0) ? 6'd0 : 6'($urandom_range(1, NCTX - 1));
      add_cmd(a, 16'($urandom), i, burst, (n % 120 == 60));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_cmds.size() != 0 || have_cur || expected_replies.size() != 0);
    repeat (10) @(posedge clk);

    if (expected_replies.size() != 0) n_mismatch++;
    $display("Covered %0d commands: %0d allocs, %0d detaches (%0d purged), %0d errors",
             n_cmds, n_alloc, n_evict, n_purge, n_err);
    $display("Checked %0d replies, %0d mismatches", n_replies, n_mismatch);
    if (n_mismatch == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout waiting for replies");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
